// File: rtl/flh_pkg.sv
package flh_pkg;

  localparam int TAPS     = 61;
  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 16;

  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = PROD_W + $clog2(TAPS);
  localparam int FRAC_W   = COEF_W - 1;
  localparam int CNT_W    = $clog2(TAPS);

  localparam int HALF_LEN  = 31;
  localparam int TABLE_LEN = 61;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  // q1.15 halves of the symmetric sets, centre tap last
  localparam int LP_HALF [HALF_LEN] = '{
    0, -17, -32, -38, -28, 0, 43, 86, 105, 79,
    0, -114, -220, -260, -189, 0, 258, 486, 565, 406,
    0, -553, -1054, -1252, -934, 0, 1475, 3239, 4921, 6129,
    6568
  };
  localparam int HP_HALF [HALF_LEN] = '{
    -19, -20, -22, -25, -29, -35, -41, -49, -58, -67,
    -78, -89, -101, -113, -126, -138, -151, -164, -176, -188,
    -200, -211, -221, -230, -238, -245, -251, -256, -260, -262,
    32525
  };

  // mac control from the sequencer
  typedef struct packed {
    logic clr;
    logic vld;
  } mac_ctrl_t;

  // rounded and clipped result from the mac
  typedef struct packed {
    logic    busy;
    sample_t data;
    logic    sat;
  } mac_res_t;

  function automatic coef_t coef_at(logic sel, int k);
    int idx;
    int c;
    int s;
    if (k < 0 || k >= TABLE_LEN) begin
      return '0;
    end
    idx = (k < HALF_LEN) ? k : (TABLE_LEN - 1 - k);
    c   = sel ? HP_HALF[idx] : LP_HALF[idx];
    if (COEF_W >= 16) begin
      c = c <<< ((COEF_W - 16) & 15);
    end else begin
      s = (16 - COEF_W) & 15;
      c = (c + ((1 << s) >>> 1)) >>> s;
    end
    return coef_t'(c);
  endfunction

endpackage

// File: rtl/flh_cell.sv
module flh_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            clr,
  input  flh_pkg::sample_t d,
  output flh_pkg::sample_t q
);

  flh_pkg::sample_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (clr) begin
      q_r <= '0;
    end else if (en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

// File: rtl/flh_mac.sv
module flh_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  flh_pkg::mac_ctrl_t ctrl,
  input  flh_pkg::sample_t   samp,
  input  flh_pkg::coef_t     coef,
  output flh_pkg::mac_res_t  res
);

  localparam int ACC_W  = flh_pkg::ACC_W;
  localparam int PROD_W = flh_pkg::PROD_W;
  localparam int FRAC_W = flh_pkg::FRAC_W;
  localparam int SW     = flh_pkg::SAMPLE_W;
  localparam int QW     = ACC_W + 1 - FRAC_W;

  localparam logic [ACC_W:0]      RND = (ACC_W + 1)'(1) << (FRAC_W - 1);
  localparam logic signed [QW-1:0] HI = QW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [QW-1:0] LO = QW'(-(64'sd1 <<< (SW - 1)));

  logic                     v1_r;
  logic                     v2_r;
  flh_pkg::coef_t           coef_r;
  flh_pkg::sample_t         samp_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic        [ACC_W:0]    rnd_sum;
  logic signed [QW-1:0]     q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctrl.vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    coef_r <= coef;
    samp_r <= samp;
    prod_r <= coef_r * samp_r;
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  // round half up, then clip
  assign rnd_sum = {acc_r[ACC_W-1], acc_r} + RND;
  assign q       = rnd_sum[ACC_W:FRAC_W];

  always_comb begin
    res.busy = v1_r | v2_r;
    res.sat  = 1'b0;
    res.data = q[SW-1:0];
    if (q > HI) begin
      res.data = HI[SW-1:0];
      res.sat  = 1'b1;
    end else if (q < LO) begin
      res.data = LO[SW-1:0];
      res.sat  = 1'b1;
    end
  end

endmodule

// File: rtl/fir_lowpass_highpass_61tap.sv
// 61-tap fir filter for photoplethysmogram samples, one filtered item per input
// item. the delay line is a ring of cells; on accepting an item the new sample
// enters the ring and the ring then rotates once per cycle through all taps,
// the tail cell feeding a single shared multiply-accumulate unit. the result
// appears once the one mac has visited every tap, its operand, product and
// accumulate registers have drained and the output register has been loaded.
// in_ready is high only between items, so the next item can be accepted in the
// same cycle as the result appears at the earliest, and a new item is never
// taken before the last one's result is loaded. the result sits in an output
// register, so the next item is taken while it waits; a result that is still
// waiting when the next one is ready holds the block until it is taken.
// register 0 at byte address 0 (filter_select, bit 0): 0 low-pass dc set,
// 1 high-pass ac set. in_record_start zeroes the delay line before its sample
// is used.
module fir_lowpass_highpass_61tap (
  input  logic                         clk,
  input  logic                         rst_n,
  // input items
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [flh_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                         in_record_start,
  // result items
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [flh_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                         out_saturated,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int TAPS  = flh_pkg::TAPS;
  localparam int CNT_W = flh_pkg::CNT_W;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(TAPS - 1);

  typedef enum logic [1:0] {IDLE, RUN, FINISH} state_t;

  state_t                  state_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    sel_r;
  logic                    out_valid_r;
  flh_pkg::sample_t        out_data_r;
  logic                    out_sat_r;

  logic                    accept;
  logic                    out_load;
  logic                    ring_en;
  logic                    ring_clr;
  flh_pkg::sample_t        cell_q [TAPS];
  flh_pkg::sample_t        head_d;
  flh_pkg::coef_t          coef;
  flh_pkg::mac_ctrl_t      mac_ctrl;
  flh_pkg::mac_res_t       mac_res;

  assign accept   = in_valid & in_ready;
  assign in_ready = (state_r == IDLE);

  // pipeline drained and the output register free or being emptied
  assign out_load = (state_r == FINISH) && !mac_res.busy && (!out_valid_r || out_ready);

  // config port: always ready, register 0 is the coefficient set select
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'b0, sel_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      sel_r <= pwdata[0];
    end
  end

  // ring of cells: shift in on accept, rotate while running
  assign ring_en  = accept | (state_r == RUN);
  assign ring_clr = accept & in_record_start;
  assign head_d   = accept ? in_sample_in : cell_q[TAPS-1];

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    if (i == 0) begin : g_head
      flh_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (ring_en),
        .clr   (1'b0),
        .d     (head_d),
        .q     (cell_q[0])
      );
    end else begin : g_body
      flh_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (ring_en),
        .clr   (ring_clr),
        .d     (cell_q[i-1]),
        .q     (cell_q[i])
      );
    end
  end

  // tail holds the oldest sample first, so taps run from last to first
  assign coef = flh_pkg::coef_at(sel_r, (TAPS - 1) - int'(cnt_r));

  assign mac_ctrl.clr = accept;
  assign mac_ctrl.vld = (state_r == RUN);

  flh_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .samp  (cell_q[TAPS-1]),
    .coef  (coef),
    .res   (mac_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        IDLE: begin
          if (accept) begin
            cnt_r   <= '0;
            state_r <= RUN;
          end
        end
        RUN: begin
          if (cnt_r == LAST) begin
            state_r <= FINISH;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        FINISH: begin
          // wait for the pipeline to drain and the output register to free
          if (out_load) begin
            out_data_r  <= mac_res.data;
            out_sat_r   <= mac_res.sat;
            state_r     <= IDLE;
          end
        end
        default: begin
          state_r <= IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;
  assign out_saturated  = out_sat_r;

endmodule
